/* hw/rtl/isw_pkg.sv */
// Shared types and constants for the IR scan-and-track stepper controller.
// No dependencies; used by the output interface and the top level.
package isw_pkg;

  // Operating phase, also reported on every result word
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SCAN   = 2'd1,
    PH_RETURN = 2'd2,
    PH_TRACK  = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 12;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWAP_SENSORS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_BAND    = 1'd1;

  localparam int DEAD_BAND_BITS = 12;
  localparam logic [DEAD_BAND_BITS-1:0] DEAD_BAND_RESET = 12'd300;

  // Widths of the fixed result fields
  localparam int TICK_BITS  = 6;
  localparam int COIL_BITS  = 4;
  localparam int INDEX_BITS = 3;

  // Half-step coil pattern, one entry per half-step position
  localparam logic [COIL_BITS-1:0] DRIVE_TABLE [8] = '{
    4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9, 4'h8, 4'hC
  };

  function automatic logic [COIL_BITS-1:0] drive_pattern(input logic [INDEX_BITS-1:0] idx);
    return DRIVE_TABLE[idx];
  endfunction

endpackage

/* hw/rtl/isw_in_if.sv */
// Input word channel of the stepper controller: one motor tick per word.
// Depends on nothing; sample width is a parameter.
interface isw_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic                   start_req;
  logic [SAMPLE_BITS-1:0] sample_a;
  logic [SAMPLE_BITS-1:0] sample_b;

  modport source (output valid, output start_req, output sample_a, output sample_b,
                  input ready);
  modport sink   (input valid, input start_req, input sample_a, input sample_b,
                  output ready);
endinterface

/* hw/rtl/isw_out_if.sv */
// Result word channel of the stepper controller: coil drive and status.
// Depends on isw_pkg for field widths.
interface isw_out_if;
  logic                           valid;
  logic                           ready;
  logic [isw_pkg::COIL_BITS-1:0]  coils;
  logic                           stepped;
  logic                           counter_clockwise;
  logic [1:0]                     phase;
  logic [isw_pkg::TICK_BITS-1:0]  best_position;

  modport source (output valid, output coils, output stepped, output counter_clockwise,
                  output phase, output best_position, input ready);
  modport sink   (input valid, input coils, input stepped, input counter_clockwise,
                  input phase, input best_position, output ready);
endinterface

/* hw/rtl/ir_scan_and_track_stepper_top.sv */
// Top level of the IR scan-and-track stepper controller.
// Depends on isw_pkg, isw_in_if and isw_out_if.

// Each input word is one motor tick and yields exactly one result word. A start
// pulse in idle begins a scan of SCAN_STEPS clockwise half-steps that records the
// tick of the lowest sample average; the motor then walks back to that tick by the
// shorter way and afterwards tracks the sensor difference against the dead band
// forever (only reset leaves tracking). Throughput is one word per cycle while result words
// are taken; each word is held in an input register, and the controller state and the
// coil pattern are updated as it moves into the result register. While a finished word
// waits to be taken, the input register can still take one more word; after that the
// input stalls until the result is read. Configuration may be written only while no word
// is in flight.
module ir_scan_and_track_stepper_top #(
  parameter int SCAN_STEPS  = 40,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  isw_in_if.sink                              in_ch,
  isw_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [isw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [isw_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int TB = isw_pkg::TICK_BITS;
  localparam int CW = (SAMPLE_BITS > isw_pkg::DEAD_BAND_BITS) ?
                      SAMPLE_BITS : isw_pkg::DEAD_BAND_BITS;
  localparam logic [TB-1:0] SCAN_LEN  = TB'(SCAN_STEPS);
  localparam logic [TB-1:0] SCAN_HALF = TB'(SCAN_STEPS / 2);

  // Configuration registers
  logic                                 swap_sensors_r;
  logic [isw_pkg::DEAD_BAND_BITS-1:0]   dead_band_r;

  // Input register
  logic                   s1_valid_r;
  logic                   s1_start_r;
  logic [SAMPLE_BITS-1:0] s1_a_r;
  logic [SAMPLE_BITS-1:0] s1_b_r;

  // Result register
  logic                              out_valid_r;
  logic [isw_pkg::COIL_BITS-1:0]     out_coils_r;
  logic                              out_stepped_r;
  logic                              out_ccw_r;
  logic [1:0]                        out_phase_r;
  logic [TB-1:0]                     out_best_r;

  // Controller state
  isw_pkg::mode_t                    mode_r, mode_nxt;
  logic [TB-1:0]                     tick_r, tick_nxt;
  logic [SAMPLE_BITS-1:0]            low_avg_r, low_avg_nxt;
  logic [TB-1:0]                     low_pos_r, low_pos_nxt;
  logic [isw_pkg::INDEX_BITS-1:0]    hsi_r, hsi_nxt;
  logic [isw_pkg::COIL_BITS-1:0]     coil_r, coil_nxt;

  logic                   s1_fire;
  logic                   in_ready;
  logic                   step;
  logic                   ccw;
  logic [SAMPLE_BITS:0]   sum;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [TB-1:0]          tick_inc;
  logic [TB-1:0]          tick_dec;
  logic [TB-1:0]          ret_len;

  // Handshake: the input register moves whenever the result register is free
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready    = !s1_valid_r || s1_fire;
  assign in_ch.ready = in_ready;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.coils             = out_coils_r;
  assign out_ch.stepped           = out_stepped_r;
  assign out_ch.counter_clockwise = out_ccw_r;
  assign out_ch.phase             = out_phase_r;
  assign out_ch.best_position     = out_best_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_sensors_r <= 1'b0;
      dead_band_r    <= isw_pkg::DEAD_BAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        isw_pkg::CFG_SWAP_SENSORS: swap_sensors_r <= cfg_data[0];
        isw_pkg::CFG_DEAD_BAND:    dead_band_r    <= cfg_data[isw_pkg::DEAD_BAND_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_start_r <= in_ch.start_req;
      s1_a_r     <= in_ch.sample_a;
      s1_b_r     <= in_ch.sample_b;
    end
  end

  // Sample arithmetic
  assign sum      = {1'b0, s1_a_r} + {1'b0, s1_b_r};
  assign avg      = sum[SAMPLE_BITS:1];
  assign mag      = (s1_a_r >= s1_b_r) ? (s1_a_r - s1_b_r) : (s1_b_r - s1_a_r);
  assign tick_inc = tick_r + TB'(1);
  assign tick_dec = tick_r - TB'(1);
  assign ret_len  = (low_pos_nxt < SCAN_HALF) ? low_pos_nxt : (SCAN_LEN - low_pos_nxt);

  // Next state and step decision
  always_comb begin
    mode_nxt    = mode_r;
    tick_nxt    = tick_r;
    low_avg_nxt = low_avg_r;
    low_pos_nxt = low_pos_r;
    step        = 1'b0;
    ccw         = 1'b0;
    case (mode_r)
      isw_pkg::PH_IDLE: begin
        if (s1_start_r) begin
          mode_nxt    = isw_pkg::PH_SCAN;
          tick_nxt    = '0;
          low_avg_nxt = '1;
          low_pos_nxt = '0;
        end
      end
      isw_pkg::PH_SCAN: begin
        if (avg < low_avg_r) begin
          low_avg_nxt = avg;
          low_pos_nxt = tick_r;
        end
        step = 1'b1;
        if (tick_inc >= SCAN_LEN) begin
          tick_nxt = ret_len;
          mode_nxt = (ret_len == '0) ? isw_pkg::PH_TRACK : isw_pkg::PH_RETURN;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      isw_pkg::PH_RETURN: begin
        step     = 1'b1;
        ccw      = !(low_pos_r < SCAN_HALF);
        tick_nxt = tick_dec;
        if (tick_dec == '0) begin
          mode_nxt = isw_pkg::PH_TRACK;
        end
      end
      isw_pkg::PH_TRACK: begin
        // Swapping the sensors flips only the sign, so the direction test swaps
        if (CW'(mag) > CW'(dead_band_r)) begin
          step = 1'b1;
          ccw  = swap_sensors_r ? (s1_b_r > s1_a_r) : (s1_a_r > s1_b_r);
        end
      end
      default: ;
    endcase
  end

  // Half-step drive: the index points one past the entry last driven
  always_comb begin
    hsi_nxt  = hsi_r;
    coil_nxt = coil_r;
    if (step) begin
      if (ccw) begin
        coil_nxt = isw_pkg::drive_pattern(hsi_r - isw_pkg::INDEX_BITS'(2));
        hsi_nxt  = hsi_r - isw_pkg::INDEX_BITS'(1);
      end else begin
        coil_nxt = isw_pkg::drive_pattern(hsi_r);
        hsi_nxt  = hsi_r + isw_pkg::INDEX_BITS'(1);
      end
    end
  end

  // Advance the controller state with each word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= isw_pkg::PH_IDLE;
      tick_r    <= '0;
      low_avg_r <= '1;
      low_pos_r <= '0;
      hsi_r     <= '0;
      coil_r    <= '0;
    end else if (s1_fire) begin
      mode_r    <= mode_nxt;
      tick_r    <= tick_nxt;
      low_avg_r <= low_avg_nxt;
      low_pos_r <= low_pos_nxt;
      hsi_r     <= hsi_nxt;
      coil_r    <= coil_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_coils_r   <= coil_nxt;
      out_stepped_r <= step;
      out_ccw_r     <= step && ccw;
      out_phase_r   <= mode_r;
      out_best_r    <= low_pos_nxt;
    end
  end

`ifndef SYNTHESIS
  // Tracking is never left
  a_track_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == isw_pkg::PH_TRACK) |=> (mode_r == isw_pkg::PH_TRACK))
    else $error("left tracking phase");

  // A step moves the half-step index by exactly one position
  a_step_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && step) |=>
      ((hsi_r == $past(hsi_r) + isw_pkg::INDEX_BITS'(1)) ||
       (hsi_r == $past(hsi_r) - isw_pkg::INDEX_BITS'(1))))
    else $error("half-step index jumped");

  // Without a step the coil drive and index hold
  a_hold_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !step) |=> ($stable(coil_r) && $stable(hsi_r)))
    else $error("coils changed without a step");

  // Scan tick count stays below the scan length
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == isw_pkg::PH_SCAN) |-> (tick_r < SCAN_LEN))
    else $error("scan tick count out of range");

  // A word handed to the result register shows up as valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("result word lost");
`endif

endmodule
